// ===== src/ipv6ehc_pkg.sv =====
// Shared types and constants for the IPv6 extension header walker.
// Stand-alone package; used by ipv6_ext_header_checksum_setup.
package ipv6ehc_pkg;

    // Parse stage codes
    localparam logic [2:0] STG_FIXED = 3'd0;
    localparam logic [2:0] STG_OPT   = 3'd1;
    localparam logic [2:0] STG_AUTH  = 3'd2;
    localparam logic [2:0] STG_FRAG  = 3'd3;
    localparam logic [2:0] STG_END   = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_PROTO = 2'd1;
    localparam logic [1:0] ST_TRUNC = 2'd2;

    // Next header protocol numbers
    localparam logic [7:0] NH_HOPOPT = 8'd0;
    localparam logic [7:0] NH_TCP    = 8'd6;
    localparam logic [7:0] NH_UDP    = 8'd17;
    localparam logic [7:0] NH_ROUTE  = 8'd43;
    localparam logic [7:0] NH_FRAG   = 8'd44;
    localparam logic [7:0] NH_AUTH   = 8'd51;
    localparam logic [7:0] NH_DSTOPT = 8'd60;

    // Configuration register indexes
    localparam logic [0:0] CFG_RECALC_EN = 1'd0;
    localparam logic [0:0] CFG_HDR_LIMIT = 1'd1;

    // Fixed header geometry
    localparam int unsigned CNT_W   = 17;
    localparam int unsigned SUM_W   = 20;
    localparam int unsigned FIX_LEN = 40;

    // Result word, first field in the highest bits
    typedef struct packed {
        logic        checksum_valid;
        logic [15:0] pseudo_checksum;
        logic [9:0]  checksum_field_offset;
        logic [9:0]  transport_offset;
        logic        is_udp;
        logic [1:0]  status;
    } t_result;

endpackage

// ===== src/ipv6_ext_header_checksum_setup.sv =====
// IPv6 extension header walker with transport pseudo-header sum.
// Depends on ipv6ehc_pkg for stage, status and protocol codes and the result type.
//
//  channel   | dir | handshake                        | payload
//  ----------+-----+----------------------------------+--------------------------------------
//  s_axis    | in  | i_s_axis_tvalid / o_s_axis_tready | tdata[7:0] data_byte, tlast last_byte
//  m_axis    | out | o_m_axis_tvalid / i_m_axis_tready | tdata[39:0] result (see port comment)
//  cfg       | in  | i_cfg_we (no wait)               | i_cfg_index, i_cfg_data
//
// One byte per cycle while ready is high: every byte request is parsed in the cycle it is
// accepted, and the last byte of a packet loads the result register, or the skid register
// while the result is held, in that same cycle. The header decision path (offset add,
// payload and limit compares) sets the cycle time. A two-entry output (result register
// plus skid register) keeps input moving for one stalled result; ready drops only while
// the skid register is occupied. Reset is synchronous, active low, and clears parse state and both output entries.
module ipv6_ext_header_checksum_setup #(
    parameter int LIMIT_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_index,
    input  logic [LIMIT_BITS-1:0] i_cfg_data,
    // packet byte stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [7:0]            i_s_axis_tdata,   // [7:0] data_byte
    input  logic                  i_s_axis_tlast,   // last_byte
    // result stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [1:0] status, [2] is_udp, [12:3] transport_offset,
    // [22:13] checksum_field_offset, [38:23] pseudo_checksum, [39] checksum_valid
    output logic [39:0]           o_m_axis_tdata
);

    localparam int CNT_W = ipv6ehc_pkg::CNT_W;
    localparam int SUM_W = ipv6ehc_pkg::SUM_W;
    // limit register must hold the reset value 256 even for narrow limits
    localparam int LIM_W = (LIMIT_BITS > 9) ? LIMIT_BITS : 9;
    // offsets stay at or below the limit plus one longest header step
    localparam int OFF_W = ((LIMIT_BITS > 11) ? LIMIT_BITS : 11) + 1;
    localparam int END_W = OFF_W + 1;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // configuration
    logic             r_recalc_en;
    logic [LIM_W-1:0] r_limit;

    // packet parse state
    logic [CNT_W-1:0] r_count,    n_count;
    logic [2:0]       r_stage,    n_stage;
    logic [7:0]       r_nh,       n_nh;
    logic [OFF_W-1:0] r_off,      n_off;
    logic [15:0]      r_pl,       n_pl;
    logic             r_done,     n_done;
    logic             r_frag,     n_frag;
    logic [1:0]       r_err,      n_err;
    logic [SUM_W-1:0] r_addr,     n_addr;
    logic [7:0]       r_hold,     n_hold;
    logic [LIM_W-1:0] r_need,     n_need;
    logic             r_udp,      n_udp;

    // output entries
    logic                 r_out_valid;
    ipv6ehc_pkg::t_result r_out;
    logic                 r_skd_valid;
    ipv6ehc_pkg::t_result r_skd;

    logic                 s_acc;
    logic                 push;
    logic                 out_free;
    logic                 do_decide;
    logic                 dec_req;
    logic                 dec_xport;
    logic [END_W-1:0]     dec_end;
    logic [7:0]           in_b;
    logic [11:0]          hdr_len;
    logic [CNT_W-1:0]     ulen;
    logic [20:0]          sum_raw;
    logic [16:0]          sum_f1;
    logic [16:0]          sum_f2;
    logic [OFF_W-1:0]     coff_full;
    ipv6ehc_pkg::t_result res;

    assign in_b            = i_s_axis_tdata;
    assign o_s_axis_tready = !r_skd_valid;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign push            = s_acc && i_s_axis_tlast;
    assign out_free        = !r_out_valid || i_m_axis_tready;

    // per-byte parse and header decision
    always_comb begin
        n_count   = r_count;
        n_stage   = r_stage;
        n_nh      = r_nh;
        n_off     = r_off;
        n_pl      = r_pl;
        n_done    = r_done;
        n_frag    = r_frag;
        n_err     = r_err;
        n_addr    = r_addr;
        n_hold    = r_hold;
        n_need    = r_need;
        n_udp     = r_udp;
        do_decide = 1'b0;
        dec_req   = 1'b0;
        dec_xport = 1'b0;
        dec_end   = '0;
        hdr_len   = '0;

        case (r_stage)
            ipv6ehc_pkg::STG_FIXED: begin
                if (r_count == CNT_W'(4) ||
                    (r_count >= CNT_W'(8) && r_count < CNT_W'(40) && !r_count[0])) begin
                    n_hold = in_b;
                end else if (r_count == CNT_W'(5)) begin
                    n_pl = {r_hold, in_b};
                end else if (r_count == CNT_W'(6)) begin
                    n_nh = in_b;
                end else if (r_count >= CNT_W'(8) && r_count < CNT_W'(40)) begin
                    n_addr = r_addr + SUM_W'({r_hold, in_b});
                end
                if (r_count == CNT_W'(39)) begin
                    if (r_limit < LIM_W'(ipv6ehc_pkg::FIX_LEN)) begin
                        n_err   = ipv6ehc_pkg::ST_TRUNC;
                        n_stage = ipv6ehc_pkg::STG_END;
                    end else begin
                        do_decide = 1'b1;
                    end
                end
            end
            ipv6ehc_pkg::STG_OPT, ipv6ehc_pkg::STG_AUTH: begin
                if (r_count == CNT_W'(r_off)) begin
                    n_nh = in_b;
                end else if (r_count == CNT_W'(r_off) + CNT_W'(1)) begin
                    // options and routing count 8-byte units, AH counts 4-byte units
                    if (r_stage == ipv6ehc_pkg::STG_OPT) begin
                        hdr_len = ({4'd0, in_b} + 12'd1) << 3;
                    end else begin
                        hdr_len = ({4'd0, in_b} + 12'd2) << 2;
                    end
                    n_off     = r_off + OFF_W'(hdr_len);
                    do_decide = 1'b1;
                end
            end
            ipv6ehc_pkg::STG_FRAG: begin
                if (r_count == CNT_W'(r_off)) begin
                    n_nh = in_b;
                end else if (r_count == CNT_W'(r_off) + CNT_W'(2)) begin
                    n_hold = in_b;
                end else if (r_count == CNT_W'(r_off) + CNT_W'(3)) begin
                    // fragment offset or more-fragments set: not a whole datagram
                    if (({r_hold, in_b} & 16'hFFF9) != 16'd0) begin
                        n_frag = 1'b1;
                    end
                    n_off     = r_off + OFF_W'(8);
                    do_decide = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (do_decide) begin
            if (CNT_W'(n_off) > CNT_W'(r_pl) + CNT_W'(ipv6ehc_pkg::FIX_LEN)) begin
                n_err   = ipv6ehc_pkg::ST_PROTO;
                n_stage = ipv6ehc_pkg::STG_END;
            end else if (n_nh == ipv6ehc_pkg::NH_HOPOPT || n_nh == ipv6ehc_pkg::NH_ROUTE ||
                         n_nh == ipv6ehc_pkg::NH_DSTOPT) begin
                n_stage = ipv6ehc_pkg::STG_OPT;
                dec_req = 1'b1;
                dec_end = END_W'(n_off) + END_W'(2);
            end else if (n_nh == ipv6ehc_pkg::NH_AUTH) begin
                n_stage = ipv6ehc_pkg::STG_AUTH;
                dec_req = 1'b1;
                dec_end = END_W'(n_off) + END_W'(12);
            end else if (n_nh == ipv6ehc_pkg::NH_FRAG) begin
                n_stage = ipv6ehc_pkg::STG_FRAG;
                dec_req = 1'b1;
                dec_end = END_W'(n_off) + END_W'(8);
            end else begin
                n_stage = ipv6ehc_pkg::STG_END;
                if (n_frag) begin
                    n_err = ipv6ehc_pkg::ST_PROTO;
                end else if (n_nh == ipv6ehc_pkg::NH_TCP || n_nh == ipv6ehc_pkg::NH_UDP) begin
                    n_udp     = (n_nh == ipv6ehc_pkg::NH_UDP);
                    dec_req   = 1'b1;
                    dec_xport = 1'b1;
                    dec_end   = END_W'(n_off) +
                                ((n_nh == ipv6ehc_pkg::NH_UDP) ? END_W'(8) : END_W'(20));
                end else begin
                    n_err = ipv6ehc_pkg::ST_PROTO;
                end
            end

            // header must end within the limit; track the furthest end read
            if (dec_req) begin
                if (dec_end > END_W'(r_limit)) begin
                    n_err   = ipv6ehc_pkg::ST_TRUNC;
                    n_stage = ipv6ehc_pkg::STG_END;
                end else begin
                    if (dec_end > END_W'(r_need)) begin
                        n_need = LIM_W'(dec_end);
                    end
                    if (dec_xport) begin
                        n_done = 1'b1;
                    end
                end
            end
        end

        if (r_count != COUNT_MAX) begin
            n_count = r_count + CNT_W'(1);
        end
    end

    // result for the last byte, from the updated parse state
    always_comb begin
        ulen      = n_count - CNT_W'(n_off);
        sum_raw   = 21'(n_addr) + 21'(ulen[CNT_W-1:16]) + 21'(ulen[15:0]) +
                    (n_udp ? 21'(ipv6ehc_pkg::NH_UDP) : 21'(ipv6ehc_pkg::NH_TCP));
        // two folds bring a 21-bit sum back into 16 bits
        sum_f1    = 17'(sum_raw[15:0]) + 17'(sum_raw[20:16]);
        sum_f2    = 17'(sum_f1[15:0]) + 17'(sum_f1[16]);
        coff_full = n_off + (n_udp ? OFF_W'(6) : OFF_W'(16));

        res = '0;
        if (n_count < CNT_W'(n_need)) begin
            res.status = ipv6ehc_pkg::ST_TRUNC;
        end else if (n_err != ipv6ehc_pkg::ST_OK) begin
            res.status = n_err;
        end else if (n_done) begin
            res.status = ipv6ehc_pkg::ST_OK;
        end else begin
            res.status = ipv6ehc_pkg::ST_TRUNC;
        end

        if (res.status == ipv6ehc_pkg::ST_OK) begin
            res.is_udp                = n_udp;
            res.transport_offset      = n_off[9:0];
            res.checksum_field_offset = coff_full[9:0];
            if (r_recalc_en) begin
                res.pseudo_checksum = sum_f2[15:0];
                res.checksum_valid  = 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_recalc_en <= 1'b1;
            r_limit     <= LIM_W'(256);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ipv6ehc_pkg::CFG_RECALC_EN: r_recalc_en <= i_cfg_data[0];
                ipv6ehc_pkg::CFG_HDR_LIMIT: r_limit     <= LIM_W'(i_cfg_data);
                default: begin
                end
            endcase
        end
    end

    // parse state: advance on each accepted byte, clear after the last one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || push) begin
            r_count <= '0;
            r_stage <= ipv6ehc_pkg::STG_FIXED;
            r_nh    <= '0;
            r_off   <= OFF_W'(ipv6ehc_pkg::FIX_LEN);
            r_pl    <= '0;
            r_done  <= 1'b0;
            r_frag  <= 1'b0;
            r_err   <= ipv6ehc_pkg::ST_OK;
            r_addr  <= '0;
            r_hold  <= '0;
            r_need  <= LIM_W'(ipv6ehc_pkg::FIX_LEN);
            r_udp   <= 1'b0;
        end else if (s_acc) begin
            r_count <= n_count;
            r_stage <= n_stage;
            r_nh    <= n_nh;
            r_off   <= n_off;
            r_pl    <= n_pl;
            r_done  <= n_done;
            r_frag  <= n_frag;
            r_err   <= n_err;
            r_addr  <= n_addr;
            r_hold  <= n_hold;
            r_need  <= n_need;
            r_udp   <= n_udp;
        end
    end

    // output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skd_valid) begin
                r_out_valid <= 1'b1;
                r_skd_valid <= 1'b0;
            end else begin
                r_out_valid <= push;
            end
        end else if (push) begin
            r_skd_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skd_valid) begin
                r_out <= r_skd;
            end else if (push) begin
                r_out <= res;
            end
        end else if (push) begin
            r_skd <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out;

    // skid entry only fills behind a held result
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid entry valid without output entry");

    a_skid_fill_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skd_valid) |-> $past(r_out_valid && !i_m_axis_tready && push))
        else $error("skid entry filled without a stalled result");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> (r_count == '0 && r_stage == ipv6ehc_pkg::STG_FIXED))
        else $error("parse state not cleared after last byte");

    a_error_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err != ipv6ehc_pkg::ST_OK || r_done) |-> r_stage == ipv6ehc_pkg::STG_END)
        else $error("walk continues after a decision");

    a_valid_means_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.checksum_valid) |-> r_out.status == ipv6ehc_pkg::ST_OK)
        else $error("checksum flagged valid on an error result");

endmodule
